// ===== sv/button_debounce_press_classifier_core_macros.svh =====
// Assertion macros shared by the button debounce press classifier RTL.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BDPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BDPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bdpc_pkg.sv =====
// Types and constants of the button debounce press classifier.
package bdpc_pkg;

   localparam int TIME_W  = 32;
   localparam int DUR_W   = 16;
   localparam int EVT_W   = 2;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   typedef logic [TIME_W-1:0] time_ms_type;
   typedef logic [DUR_W-1:0]  dur_ms_type;

   typedef enum logic [EVT_W-1:0] {
      EVT_NONE  = 2'd0,
      EVT_SHORT = 2'd1,
      EVT_LONG  = 2'd2
   } press_event_type;

   typedef enum logic [1:0] {
      REG_ACTIVE_LEVEL    = 2'd0,
      REG_DEBOUNCE_TIME   = 2'd1,
      REG_LONG_PRESS_TIME = 2'd2
   } reg_index_type;

   localparam dur_ms_type DEBOUNCE_RESET   = 16'd50;
   localparam dur_ms_type LONG_PRESS_RESET = 16'd1000;

endpackage

// ===== sv/bdpc_req_if.sv =====
// Poll channel: one word is a raw pin sample with its millisecond timestamp.
interface bdpc_req_if;
   import bdpc_pkg::*;

   logic        valid;
   logic        ready;
   logic        raw_level;
   time_ms_type now_ms;

   modport source (output valid, output raw_level, output now_ms, input ready);
   modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

// ===== sv/bdpc_rsp_if.sv =====
// Result channel: one word is the press event reported for one poll.
interface bdpc_rsp_if;
   import bdpc_pkg::*;

   logic             valid;
   logic             ready;
   logic [EVT_W-1:0] press_event;

   modport source (output valid, output press_event, input ready);
   modport sink (input valid, input press_event, output ready);
endinterface

// ===== sv/button_debounce_press_classifier_core.sv =====
// Top level of the button debounce and short/long press classifier.
//
//   Channel  Direction  Handshake           Word
//   req_bus  in         valid/ready         raw_level, now_ms
//   rsp_bus  out        valid/ready         press_event
//   csr_*    in         APB write/read      active_level, debounce_time, long_press_time
//
// An accepted poll's result word appears in the output register in the next cycle.
// One poll can be accepted every clock while no result word is stalled; the state update is a single pass of two 32-bit
// subtractions and compares between the poll and the result register.
// A stalled result holds the output register and stops new polls until it is taken.
// Reset is synchronous and restores the register defaults and the uninitialized state.
`include "button_debounce_press_classifier_core_macros.svh"

module button_debounce_press_classifier_core (
   input  logic                           clock,
   input  logic                           reset,
   bdpc_req_if.sink                       req_bus,
   bdpc_rsp_if.source                     rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bdpc_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [bdpc_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [bdpc_pkg::DATA_W-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import bdpc_pkg::*;

   logic            active_level_ff;
   dur_ms_type      debounce_ff;
   dur_ms_type      long_press_ff;

   logic            started_ff;
   logic            last_raw_ff;
   logic            stable_ff;
   time_ms_type     change_time_ff;
   time_ms_type     press_start_ff;

   logic            started_in;
   logic            last_raw_in;
   logic            stable_in;
   time_ms_type     change_time_in;
   time_ms_type     press_start_in;

   logic            rsp_valid_ff;
   press_event_type rsp_event_ff;
   press_event_type event_in;

   logic            req_accept;
   logic            csr_write;
   reg_index_type   csr_index;
   logic            raw_changed;
   time_ms_type     held_ms;
   time_ms_type     press_ms;
   logic            debounce_done;
   logic            is_long;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= 1'b0;
         debounce_ff     <= DEBOUNCE_RESET;
         long_press_ff   <= LONG_PRESS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ACTIVE_LEVEL:    active_level_ff <= csr_pwdata[0];
            REG_DEBOUNCE_TIME:   debounce_ff     <= csr_pwdata[DUR_W-1:0];
            REG_LONG_PRESS_TIME: long_press_ff   <= csr_pwdata[DUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ACTIVE_LEVEL:    csr_prdata = {{(DATA_W-1){1'b0}}, active_level_ff};
         REG_DEBOUNCE_TIME:   csr_prdata = {{(DATA_W-DUR_W){1'b0}}, debounce_ff};
         REG_LONG_PRESS_TIME: csr_prdata = {{(DATA_W-DUR_W){1'b0}}, long_press_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign raw_changed   = req_bus.raw_level != last_raw_ff;
   assign held_ms       = raw_changed ? '0 : (req_bus.now_ms - change_time_ff);
   assign press_ms      = req_bus.now_ms - press_start_ff;
   assign debounce_done = held_ms >= {{(TIME_W-DUR_W){1'b0}}, debounce_ff};
   assign is_long       = press_ms >= {{(TIME_W-DUR_W){1'b0}}, long_press_ff};

   always_comb begin
      started_in     = started_ff;
      last_raw_in    = last_raw_ff;
      stable_in      = stable_ff;
      change_time_in = change_time_ff;
      press_start_in = press_start_ff;
      event_in       = EVT_NONE;
      if (!started_ff) begin
         started_in     = 1'b1;
         last_raw_in    = req_bus.raw_level;
         stable_in      = req_bus.raw_level;
         change_time_in = req_bus.now_ms;
         press_start_in = req_bus.now_ms;
      end else begin
         if (raw_changed) begin
            last_raw_in    = req_bus.raw_level;
            change_time_in = req_bus.now_ms;
         end
         if (debounce_done && (req_bus.raw_level != stable_ff)) begin
            stable_in = req_bus.raw_level;
            if (req_bus.raw_level == active_level_ff) begin
               press_start_in = req_bus.now_ms;
            end else if (is_long) begin
               event_in = EVT_LONG;
            end else begin
               event_in = EVT_SHORT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         last_raw_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
         press_start_ff <= '0;
      end else if (req_accept) begin
         started_ff     <= started_in;
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         press_start_ff <= press_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_event_ff <= event_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.press_event = rsp_event_ff;

   `BDPC_ASSERT_NOW(a_stall_blocks_poll, clock, reset,
      rsp_valid_ff && !rsp_bus.ready, !req_bus.ready,
      "Poll accepted while a result word is stalled.")
   `BDPC_ASSERT_NEXT(a_poll_gives_word, clock, reset,
      req_accept, rsp_valid_ff,
      "Accepted poll did not produce a result word.")
   `BDPC_ASSERT_NEXT(a_first_poll_silent, clock, reset,
      req_accept && !started_ff, rsp_event_ff == EVT_NONE,
      "First poll after reset reported a press.")
   `BDPC_ASSERT_NOW(a_event_after_start, clock, reset,
      rsp_valid_ff && (rsp_event_ff != EVT_NONE), started_ff,
      "Press reported before the state was initialized.")

endmodule
